### rtl/core/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants of the trade aggregator
// Table geometry, status codes, record layout and controller commands.
// ----------------------------------------------------------------------------
package pta_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam int QUO_W = 31;
   localparam int CNT_W = $clog2(QUO_W + 1);

   localparam logic [1:0] ST_UPDATED  = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic FUNC_TRADE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef struct packed {
      logic [39:0] last_time;
      logic [39:0] gap;
      logic [47:0] volume;
      logic [62:0] notional;
      logic [30:0] peak;
   } record_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic fetch;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

### rtl/core/pta_if.sv
// ----------------------------------------------------------------------------
// pta_if: request and response channels
// Valid/ready channels carrying trade items and entry results.
// ----------------------------------------------------------------------------
interface pta_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [39:0] trade_time;
   logic [23:0] ticker;
   logic [30:0] trade_volume;
   logic [30:0] trade_price;
   logic [5:0]  read_index;

   modport source (output valid, func, trade_time, ticker, trade_volume, trade_price,
                   read_index, input ready);
   modport sink (input valid, func, trade_time, ticker, trade_volume, trade_price,
                 read_index, output ready);
endinterface

interface pta_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  entry_index;
   logic [23:0] entry_ticker;
   logic [39:0] largest_gap;
   logic [47:0] volume_sum;
   logic [62:0] notional_sum;
   logic [30:0] mean_price;
   logic [30:0] peak_price;

   modport source (output valid, status, entry_index, entry_ticker, largest_gap,
                   volume_sum, notional_sum, mean_price, peak_price, input ready);
   modport sink (input valid, status, entry_index, entry_ticker, largest_gap,
                 volume_sum, notional_sum, mean_price, peak_price, output ready);
endinterface

### rtl/core/per_symbol_trade_aggregator_core.sv
// ----------------------------------------------------------------------------
// per_symbol_trade_aggregator_core: per-symbol trade statistics table
// Keeps up to 64 symbols with largest gap, volume, notional, peak and mean
// price. An item passes a parallel key match, a record memory read, an
// update and 31 steps of the bit-serial mean price divider before its
// result is valid; a zero volume or a saturating mean skips the steps. One
// item is in flight, so a new item is taken only after the previous result
// has been transferred.
// ----------------------------------------------------------------------------
module per_symbol_trade_aggregator_core (
   input  logic      clock,
   input  logic      reset,
   pta_req_if.sink   req,
   pta_rsp_if.source rsp
);

   pta_pkg::cmd_type  cmd;
   pta_pkg::stat_type stat;

   pta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pta_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

### rtl/core/pta_divider.sv
// ----------------------------------------------------------------------------
// pta_divider: iterative mean price divider
// Restoring division, one quotient bit per cycle, saturating to 31 bits.
// ----------------------------------------------------------------------------
module pta_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [47:0] divisor,
   output logic [30:0] quotient,
   output logic        done
);

   logic [pta_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] div_ff, div_in;
   logic [30:0] dvd_ff, dvd_in;
   logic [30:0] quo_ff, quo_in;
   logic [48:0] trial;

   assign trial = {rem_ff, dvd_ff[30]};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      if (start) begin
         div_in = divisor;
         rem_in = {16'd0, dividend[62:31]};
         dvd_in = dividend[30:0];
         quo_in = '0;
         if (divisor == 48'd0) begin
            cnt_in = '0;
         end else if ({16'd0, dividend[62:31]} >= divisor) begin
            quo_in = '1;
            cnt_in = '0;
         end else begin
            cnt_in = pta_pkg::CNT_W'(pta_pkg::QUO_W);
         end
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[29:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 48'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[29:0], 1'b1};
         end else begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done = (cnt_ff == '0) && !start;

endmodule

### rtl/core/pta_datapath.sv
// ----------------------------------------------------------------------------
// pta_datapath: symbol table and statistics datapath
// Key match, record memory, saturating update, result register, divider.
// ----------------------------------------------------------------------------
module pta_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pta_pkg::cmd_type  cmd,
   output pta_pkg::stat_type stat,
   pta_req_if.sink           req,
   pta_rsp_if.source         rsp
);

   // captured item
   logic        func_ff;
   logic [39:0] time_ff;
   logic [23:0] tick_ff;
   logic [30:0] vol_ff;
   logic [30:0] price_ff;
   logic [5:0]  ridx_ff;

   // table
   logic [23:0] keys_ff [pta_pkg::TABLE_DEPTH];
   logic [pta_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [pta_pkg::FILL_W-1:0] fill_ff;
   pta_pkg::record_type mem [pta_pkg::TABLE_DEPTH];
   pta_pkg::record_type rd_ff;

   // lookup results
   logic [pta_pkg::IDX_W-1:0] sel_ff, sel_in;
   logic [1:0] kind_ff, kind_in;
   logic       blank_ff, blank_in;
   logic [61:0] prod_ff;

   logic       hit;
   logic [pta_pkg::IDX_W-1:0] hit_idx;
   logic       ridx_ok;

   // result register
   logic [1:0]  status_ff;
   logic [5:0]  index_ff;
   logic [23:0] rtick_ff;
   logic [39:0] gap_ff;
   logic [47:0] vsum_ff;
   logic [62:0] nsum_ff;
   logic [30:0] peak_ff;

   pta_pkg::record_type rec_in;
   logic [48:0] vadd;
   logic [63:0] nadd;
   logic [39:0] g;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = pta_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && keys_ff[i] == tick_ff) begin
            hit = 1'b1;
            hit_idx = pta_pkg::IDX_W'(i);
         end
      end
   end

   assign ridx_ok = ({26'd0, ridx_ff} < 32'(pta_pkg::TABLE_DEPTH));

   always_comb begin
      sel_in = '0;
      kind_in = pta_pkg::ST_UPDATED;
      blank_in = 1'b0;
      if (func_ff == pta_pkg::FUNC_READ) begin
         sel_in = pta_pkg::IDX_W'(ridx_ff);
         if (ridx_ok && valid_ff[pta_pkg::IDX_W'(ridx_ff)]) begin
            kind_in = pta_pkg::ST_UPDATED;
         end else begin
            kind_in = pta_pkg::ST_EMPTY;
            blank_in = 1'b1;
         end
      end else if (hit) begin
         sel_in = hit_idx;
         kind_in = pta_pkg::ST_UPDATED;
      end else if (fill_ff == pta_pkg::FILL_W'(pta_pkg::TABLE_DEPTH)) begin
         kind_in = pta_pkg::ST_FULL;
         blank_in = 1'b1;
      end else begin
         sel_in = pta_pkg::IDX_W'(fill_ff);
         kind_in = pta_pkg::ST_INSERTED;
      end
   end

   always_comb begin
      rec_in = rd_ff;
      vadd = {1'b0, rd_ff.volume} + {18'd0, vol_ff};
      nadd = {1'b0, rd_ff.notional} + {2'd0, prod_ff};
      g = time_ff - rd_ff.last_time;
      if (kind_ff == pta_pkg::ST_INSERTED) begin
         rec_in.last_time = time_ff;
         rec_in.gap = '0;
         rec_in.volume = {17'd0, vol_ff};
         rec_in.notional = {1'b0, prod_ff};
         rec_in.peak = price_ff;
      end else if (func_ff == pta_pkg::FUNC_TRADE) begin
         if (time_ff >= rd_ff.last_time && g > rd_ff.gap) begin
            rec_in.gap = g;
         end
         rec_in.last_time = time_ff;
         rec_in.volume = vadd[48] ? '1 : vadd[47:0];
         rec_in.notional = nadd[63] ? '1 : nadd[62:0];
         if (price_ff > rd_ff.peak) begin
            rec_in.peak = price_ff;
         end
      end
      if (blank_ff) begin
         rec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req.func;
         time_ff <= req.trade_time;
         tick_ff <= req.ticker;
         vol_ff <= req.trade_volume;
         price_ff <= req.trade_price;
         ridx_ff <= req.read_index;
      end
      if (cmd.lookup) begin
         sel_ff <= sel_in;
         kind_ff <= kind_in;
         blank_ff <= blank_in;
         prod_ff <= 62'({31'd0, price_ff} * {31'd0, vol_ff});
      end
      if (cmd.fetch) begin
         rd_ff <= mem[sel_ff];
      end
      if (cmd.update && !blank_ff && func_ff == pta_pkg::FUNC_TRADE) begin
         mem[sel_ff] <= rec_in;
      end
      if (cmd.update && kind_ff == pta_pkg::ST_INSERTED) begin
         keys_ff[sel_ff] <= tick_ff;
      end
      if (cmd.update) begin
         status_ff <= kind_ff;
         index_ff <= blank_ff ? (kind_ff == pta_pkg::ST_EMPTY ? ridx_ff : 6'd0)
                              : 6'(sel_ff);
         rtick_ff <= blank_ff ? 24'd0 :
                     (kind_ff == pta_pkg::ST_INSERTED) ? tick_ff : keys_ff[sel_ff];
         gap_ff <= rec_in.gap;
         vsum_ff <= rec_in.volume;
         nsum_ff <= rec_in.notional;
         peak_ff <= rec_in.peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.update && kind_ff == pta_pkg::ST_INSERTED) begin
         valid_ff[sel_ff] <= 1'b1;
         fill_ff <= fill_ff + 1'b1;
      end
   end

   pta_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .dividend (rec_in.notional),
      .divisor  (rec_in.volume),
      .quotient (rsp.mean_price),
      .done     (stat.div_done)
   );

   assign rsp.status = status_ff;
   assign rsp.entry_index = index_ff;
   assign rsp.entry_ticker = rtick_ff;
   assign rsp.largest_gap = gap_ff;
   assign rsp.volume_sum = vsum_ff;
   assign rsp.notional_sum = nsum_ff;
   assign rsp.peak_price = peak_ff;

endmodule

### rtl/core/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl: item sequencer
// Steps each item through capture, lookup, fetch, update, divide, respond.
// ----------------------------------------------------------------------------
module pta_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pta_pkg::stat_type stat,
   output pta_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOKUP  = 3'd1;
   localparam logic [2:0] S_FETCH   = 3'd2;
   localparam logic [2:0] S_UPDATE  = 3'd3;
   localparam logic [2:0] S_DIVIDE  = 3'd4;
   localparam logic [2:0] S_RESPOND = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_LOOKUP;
         S_LOOKUP:  state_in = S_FETCH;
         S_FETCH:   state_in = S_UPDATE;
         S_UPDATE:  state_in = S_DIVIDE;
         S_DIVIDE:  if (stat.div_done) state_in = S_RESPOND;
         S_RESPOND: if (rsp_ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = (state_ff == S_RESPOND);
   assign cmd.capture = req_ready && req_valid;
   assign cmd.lookup = (state_ff == S_LOOKUP);
   assign cmd.fetch = (state_ff == S_FETCH);
   assign cmd.update = (state_ff == S_UPDATE);

endmodule

### tb/pta_tb_checker.sv
// ----------------------------------------------------------------------------
// pta_tb_checker: result predictor and scoreboard for the trade aggregator
// Watches request and response transfers, keeps its own copy of the symbol
// table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module pta_tb_checker (
   input  logic    clock,
   input  logic    reset,
   pta_req_if.sink req,
   pta_rsp_if.sink rsp,
   output int      fail_count,
   output int      pending_count,
   output int      result_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  entry_index;
      logic [23:0] entry_ticker;
      logic [39:0] largest_gap;
      logic [47:0] volume_sum;
      logic [62:0] notional_sum;
      logic [30:0] mean_price;
      logic [30:0] peak_price;
   } entry_result_type;

   localparam logic [47:0] VOL_MAX = {48{1'b1}};
   localparam logic [62:0] NOT_MAX = {63{1'b1}};

   logic [23:0]         sym_key [pta_pkg::TABLE_DEPTH];
   logic                sym_used [pta_pkg::TABLE_DEPTH];
   pta_pkg::record_type sym_rec [pta_pkg::TABLE_DEPTH];
   int                  sym_fill;
   entry_result_type    expected_results [$];

   function automatic entry_result_type entry_view(logic [1:0] st, int i);
      entry_result_type r;
      logic [63:0] q;
      r = '0;
      r.status       = st;
      r.entry_index  = i[5:0];
      r.entry_ticker = sym_key[i];
      r.largest_gap  = sym_rec[i].gap;
      r.volume_sum   = sym_rec[i].volume;
      r.notional_sum = sym_rec[i].notional;
      r.peak_price   = sym_rec[i].peak;
      if (sym_rec[i].volume != 0) begin
         q = {1'b0, sym_rec[i].notional} / {16'd0, sym_rec[i].volume};
         r.mean_price = (q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
      end
      return r;
   endfunction

   function automatic entry_result_type apply_trade(logic fn, logic [39:0] t, logic [23:0] tk,
                                                    logic [30:0] vol, logic [30:0] px,
                                                    logic [5:0] ri);
      entry_result_type r;
      logic [63:0] prod;
      logic [63:0] s;
      r = '0;
      prod = {33'd0, px} * {33'd0, vol};
      if (fn == pta_pkg::FUNC_READ) begin
         if (int'(ri) < pta_pkg::TABLE_DEPTH && sym_used[ri])
            return entry_view(pta_pkg::ST_UPDATED, int'(ri));
         r.status = pta_pkg::ST_EMPTY;
         r.entry_index = ri;
         return r;
      end
      for (int i = 0; i < sym_fill; i++) begin
         if (sym_used[i] && sym_key[i] == tk) begin
            if (t >= sym_rec[i].last_time && t - sym_rec[i].last_time > sym_rec[i].gap)
               sym_rec[i].gap = t - sym_rec[i].last_time;
            sym_rec[i].last_time = t;
            s = {16'd0, sym_rec[i].volume} + {33'd0, vol};
            sym_rec[i].volume = (s > {16'd0, VOL_MAX}) ? VOL_MAX : s[47:0];
            s = {1'b0, sym_rec[i].notional} + prod;
            sym_rec[i].notional = (s > {1'b0, NOT_MAX}) ? NOT_MAX : s[62:0];
            if (px > sym_rec[i].peak) sym_rec[i].peak = px;
            return entry_view(pta_pkg::ST_UPDATED, i);
         end
      end
      if (sym_fill >= pta_pkg::TABLE_DEPTH) begin
         r.status = pta_pkg::ST_FULL;
         return r;
      end
      sym_key[sym_fill]  = tk;
      sym_used[sym_fill] = 1'b1;
      sym_rec[sym_fill]  = '{last_time: t, gap: '0, volume: {17'd0, vol},
                            notional: prod[62:0], peak: px};
      sym_fill++;
      return entry_view(pta_pkg::ST_INSERTED, sym_fill - 1);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
               result_count);
      fail_count++;
   endtask

   assign pending_count = expected_results.size();

   initial begin
      fail_count = 0;
      result_count = 0;
      sym_fill = 0;
      foreach (sym_used[i]) sym_used[i] = 1'b0;
   end

   always @(posedge clock) begin
      entry_result_type want;
      if (!reset) begin
         if (req.valid && req.ready)
            expected_results = {expected_results,
                                apply_trade(req.func, req.trade_time, req.ticker,
                                            req.trade_volume, req.trade_price,
                                            req.read_index)};
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 64'd0, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.status != want.status) report_mismatch("status", rsp.status, want.status);
               if (rsp.entry_index != want.entry_index)
                  report_mismatch("entry_index", rsp.entry_index, want.entry_index);
               if (rsp.entry_ticker != want.entry_ticker)
                  report_mismatch("entry_ticker", rsp.entry_ticker, want.entry_ticker);
               if (rsp.largest_gap != want.largest_gap)
                  report_mismatch("largest_gap", rsp.largest_gap, want.largest_gap);
               if (rsp.volume_sum != want.volume_sum)
                  report_mismatch("volume_sum", rsp.volume_sum, want.volume_sum);
               if (rsp.notional_sum != want.notional_sum)
                  report_mismatch("notional_sum", rsp.notional_sum, want.notional_sum);
               if (rsp.mean_price != want.mean_price)
                  report_mismatch("mean_price", rsp.mean_price, want.mean_price);
               if (rsp.peak_price != want.peak_price)
                  report_mismatch("peak_price", rsp.peak_price, want.peak_price);
            end
         end
      end
   end

endmodule

### tb/per_symbol_trade_aggregator_core_tb.sv
// ----------------------------------------------------------------------------
// per_symbol_trade_aggregator_core_tb: stimulus and verdict
// Drives directed and random trade and read items with random gaps and
// response stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module per_symbol_trade_aggregator_core_tb;

   localparam int RANDOM_ITEMS = 1680;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   result_count;
   int   sent_count;
   logic [23:0] ticker_pool [16];
   logic [39:0] clock_now;

   pta_req_if req ();
   pta_rsp_if rsp ();

   per_symbol_trade_aggregator_core DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   pta_tb_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   always #6 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.func = pta_pkg::FUNC_TRADE;
      req.trade_time = '0;
      req.ticker = '0;
      req.trade_volume = '0;
      req.trade_price = '0;
      req.read_index = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid || !rsp.ready) @(posedge clock);
      end
   end

   task automatic send_item(logic fn, logic [39:0] t, logic [23:0] tk, logic [30:0] vol,
                            logic [30:0] px, logic [5:0] ri, bit no_gap);
      int gap;
      gap = no_gap ? 0 : int'($urandom_range(0, 12));
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= fn;
      req.trade_time <= t;
      req.ticker <= tk;
      req.trade_volume <= vol;
      req.trade_price <= px;
      req.read_index <= ri;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
   endtask

   initial begin
      logic [30:0] vmax;
      logic [39:0] tmax;
      bit burst;
      int kind;
      vmax = 31'h7FFF_FFFF;
      tmax = 40'hFF_FFFF_FFFF;
      sent_count = 0;
      burst = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty reads, extremes, saturation, time going backwards
      send_item(pta_pkg::FUNC_READ, 40'd0, 24'd0, 31'd0, 31'd0, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_READ, tmax, 24'hFFFFFF, vmax, vmax, 6'd63, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd0, 24'h000000, 31'd0, 31'd0, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd0, 24'h000000, 31'd0, vmax, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd0, 24'hFFFFFF, vmax, vmax, 6'h3F, 1'b0);
      repeat (4) send_item(pta_pkg::FUNC_TRADE, tmax, 24'hFFFFFF, vmax, vmax, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd10, 24'hFFFFFF, vmax, 31'd1, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd5, 24'h414243, 31'd1, vmax, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd2, 24'h414243, 31'd3, 31'd7, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_TRADE, 40'd100, 24'h414243, 31'd0, 31'd0, 6'd0, 1'b0);
      send_item(pta_pkg::FUNC_READ, 40'd0, 24'd0, 31'd0, 31'd0, 6'd1, 1'b0);
      send_item(pta_pkg::FUNC_READ, 40'd0, 24'd0, 31'd0, 31'd0, 6'd2, 1'b0);
      send_item(pta_pkg::FUNC_READ, 40'd0, 24'd0, 31'd0, 31'd0, 6'd3, 1'b0);
      // random: mostly repeats of a small symbol pool, rising timestamps
      foreach (ticker_pool[i]) ticker_pool[i] = 24'($urandom());
      clock_now = 40'd1000;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [23:0] tk;
         logic [30:0] vol, px;
         logic [39:0] t;
         if (n % 200 == 0) burst = ($urandom_range(0, 1) == 1);
         kind = int'($urandom_range(0, 99));
         clock_now += ($urandom_range(0, 3) == 0) ? 40'({$urandom(), 8'd0})
                                                  : 40'($urandom_range(0, 500));
         t = ($urandom_range(0, 19) == 0) ? 40'({$urandom(), $urandom()}) : clock_now;
         tk = (kind < 55) ? ticker_pool[$urandom_range(0, 15)] : 24'($urandom());
         vol = ($urandom_range(0, 9) == 0) ? vmax - 31'($urandom_range(0, 3))
                                           : 31'($urandom_range(0, 5000));
         px = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 100000));
         if (kind >= 85)
            send_item(pta_pkg::FUNC_READ, 40'({$urandom(), $urandom()}), 24'($urandom()),
                      31'($urandom()), 31'($urandom()), 6'($urandom_range(0, 63)), burst);
         else
            send_item(pta_pkg::FUNC_TRADE, t, tk, vol, px, 6'($urandom()), burst);
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d items and %0d results: inserts, updates, full table drops,",
               sent_count, result_count);
      $display("saturating sums, backward time and empty reads under random stalls");
      if (fail_count == 0 && pending_count == 0)
         $display("[per_symbol_trade_aggregator_core] OK");
      else
         $display("[per_symbol_trade_aggregator_core] ERROR");
      $finish;
   end

   initial begin
      #6000000;
      $display("[per_symbol_trade_aggregator_core] ERROR");
      $finish;
   end

endmodule
